// ----- hdl/arpc_pkg.sv -----
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int ARPC_TABLE_DEPTH = 16;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int AGE_W  = 16;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [IP_W-1:0]  OWN_IP_RST    = 32'hACA8_2000;
    localparam logic [MAC_W-1:0] OWN_MAC_RST   = 48'h1111_1111_1100;
    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 16'd1000;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP  = 3'd0,
        KIND_REQUEST = 3'd1,
        KIND_REPLY   = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_FRAME   = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_IP    = 2'd0,
        CFG_OWN_MAC   = 2'd1,
        CFG_AGE_LIMIT = 2'd2
    } cfg_idx_t;

    // One table entry as stored in the entry RAM
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } entry_t;

endpackage

// ----- hdl/arpc_ram.sv -----
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/arp_cache_with_aging_top.sv -----
`timescale 1ns / 1ps

// ARP cache with per-entry aging.
// Command channel: present kind, ip_addr and mac_addr with start; the item
// transfers at a rising edge with start high and busy low. Every item gives
// exactly one result, shown for one cycle with done high; the receiver
// cannot stall, so sample the result ports whenever done is high.
// Request, data frame and unknown kinds resolve at once: done rises in the
// cycle after the transfer and busy stays low. Lookup, reply and tick scan
// the whole table through one entry RAM read port and one compare/decrement
// unit, one entry per cycle, with busy high until done rises; the next item
// may transfer in the done cycle.
// Configuration channel: cfg_index selects own_ip (0), own_mac (1) or
// age_limit (2); cfg_ready is always high, other indexes are dropped. Write
// configuration only while the block is idle.
// Reset clears all valid bits and loads the register defaults; entry
// contents are never used before they are written, so the RAM is not swept.
module arp_cache_with_aging_top
    import arpc_pkg::*;
#(
    parameter int TABLE_DEPTH = ARPC_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [IP_W-1:0]       ip_addr,
    input  logic [MAC_W-1:0]      mac_addr,

    // result channel
    output logic                  done,
    output logic                  hit,
    output logic [MAC_W-1:0]      mac_out,
    output logic                  send_request,
    output logic                  send_reply,
    output logic                  table_full,
    output logic                  accept_frame,

    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic [AGE_W-1:0] age_limit_reg;

    // latched command
    kind_t            kind_reg;
    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;

    // scan pipeline: issue stage drives the RAM address, compare stage
    // sees the registered read data in the following cycle
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;

    // search results
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [MAC_W-1:0] found_mac_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // result registers
    logic             done_reg;
    logic             hit_reg;
    logic [MAC_W-1:0] mac_out_reg;
    logic             send_request_reg;
    logic             send_reply_reg;
    logic             table_full_reg;
    logic             accept_frame_reg;

    // entry RAM
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;

    logic accept_cmd;
    logic cmp_entry_valid;
    logic cmp_match;
    logic tick_expire;
    logic tick_write;
    logic reply_write;

    assign accept_cmd = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    arpc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    // Shared compare/decrement unit on the entry in the compare stage.
    assign cmp_entry_valid = cmp_vld_reg && valid_reg[cmp_idx_reg];
    assign cmp_match       = cmp_entry_valid && (rd_entry.ip == ip_reg);
    assign tick_expire     = (kind_reg == KIND_TICK) && cmp_entry_valid
                             && (rd_entry.age <= AGE_W'(1));
    assign tick_write      = (kind_reg == KIND_TICK) && cmp_entry_valid
                             && (rd_entry.age > AGE_W'(1));
    assign reply_write     = (state_reg == ST_FINISH) && (kind_reg == KIND_REPLY)
                             && (found_reg || free_found_reg);

    always_comb
    begin
        ram_we    = tick_write || reply_write;
        ram_waddr = cmp_idx_reg;
        wr_entry  = rd_entry;
        if (reply_write)
        begin
            // refresh the matching entry, else learn into the first free slot
            ram_waddr    = found_reg ? found_idx_reg : free_idx_reg;
            wr_entry.ip  = ip_reg;
            wr_entry.mac = mac_reg;
            wr_entry.age = age_limit_reg;
        end
        else
        begin
            wr_entry.age = rd_entry.age - AGE_W'(1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_cmd && ((kind_t'(kind) == KIND_LOOKUP)
                                   || (kind_t'(kind) == KIND_REPLY)
                                   || (kind_t'(kind) == KIND_TICK)))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            own_ip_reg    <= OWN_IP_RST;
            own_mac_reg   <= OWN_MAC_RST;
            age_limit_reg <= AGE_LIMIT_RST;
            valid_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            done_reg    <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_OWN_IP:    own_ip_reg    <= cfg_data[IP_W-1:0];
                    CFG_OWN_MAC:   own_mac_reg   <= cfg_data[MAC_W-1:0];
                    CFG_AGE_LIMIT: age_limit_reg <= cfg_data[AGE_W-1:0];
                    default:       ;
                endcase
            end

            // drop expired entries during a tick scan
            if (tick_expire)
            begin
                valid_reg[cmp_idx_reg] <= 1'b0;
            end
            // a learned entry becomes valid
            if (reply_write && !found_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end

            if (accept_cmd)
            begin
                done_reg <= !((kind_t'(kind) == KIND_LOOKUP)
                              || (kind_t'(kind) == KIND_REPLY)
                              || (kind_t'(kind) == KIND_TICK));
            end
            if (state_reg == ST_FINISH)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;

        if (accept_cmd)
        begin
            kind_reg       <= kind_t'(kind);
            ip_reg         <= ip_addr;
            mac_reg        <= mac_addr;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;

            // immediate kinds: settle the result now
            hit_reg          <= 1'b0;
            mac_out_reg      <= '0;
            send_request_reg <= 1'b0;
            send_reply_reg   <= 1'b0;
            table_full_reg   <= 1'b0;
            accept_frame_reg <= 1'b0;
            case (kind_t'(kind))
                KIND_REQUEST:
                begin
                    if (ip_addr == own_ip_reg)
                    begin
                        send_reply_reg <= 1'b1;
                        mac_out_reg    <= mac_addr;
                    end
                end
                KIND_FRAME:
                begin
                    accept_frame_reg <= (mac_addr == own_mac_reg);
                end
                default: ;
            endcase
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            // lowest index wins for both searches
            if (cmp_match && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= cmp_idx_reg;
                found_mac_reg <= rd_entry.mac;
            end
            if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end

            if (state_reg == ST_FINISH)
            begin
                hit_reg          <= 1'b0;
                mac_out_reg      <= '0;
                send_request_reg <= 1'b0;
                send_reply_reg   <= 1'b0;
                table_full_reg   <= 1'b0;
                accept_frame_reg <= 1'b0;
                case (kind_reg)
                    KIND_LOOKUP:
                    begin
                        hit_reg          <= found_reg;
                        mac_out_reg      <= found_reg ? found_mac_reg : '0;
                        send_request_reg <= !found_reg;
                    end
                    KIND_REPLY:
                    begin
                        table_full_reg <= !(found_reg || free_found_reg);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign mac_out      = mac_out_reg;
    assign send_request = send_request_reg;
    assign send_reply   = send_reply_reg;
    assign table_full   = table_full_reg;
    assign accept_frame = accept_frame_reg;

    // a result never appears while a scan is still running
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // every transfer either starts a scan or yields its result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transfer neither scanned nor answered");

    // the final sequencer step always delivers a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> done)
        else $error("scan finished without a result");

    // at most one action flag per result
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({hit, send_request, send_reply, table_full, accept_frame}))
        else $error("conflicting result flags");

    // the entry RAM is written only under an active scan or commit
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> busy)
        else $error("entry RAM written while idle");

endmodule
